// File: rtl/core/ppem_pkg.sv
// ----------------------------------------------------------------------------
// ppem_pkg
// Shared types and constants for the perfect power exponent mask core.
// ----------------------------------------------------------------------------
package ppem_pkg;

  // Input value width and the magnitude width of a non-negative value
  localparam int VALUE_BITS = 32;
  localparam int MAG_BITS   = VALUE_BITS - 1;

  // Exponent range and mask width
  localparam int EXP_BITS  = 5;
  localparam int MAX_EXP   = 31;
  localparam int MASK_BITS = 30;

  // Root search bounds: candidates run from 2 up to 2^16
  localparam int ROOT_BITS = 17;
  localparam logic [ROOT_BITS-1:0] ROOT_LO = 17'd2;
  localparam logic [ROOT_BITS-1:0] ROOT_HI = 17'h10000;

  // Saturating power accumulator: holds up to limit + 1 <= 2^31
  localparam int POW_BITS  = 32;
  localparam int PROD_BITS = POW_BITS + ROOT_BITS;

  // max_exponent reset value and first exponent tested
  localparam logic [EXP_BITS-1:0] MAX_EXP_RESET = 5'd31;
  localparam logic [EXP_BITS-1:0] FIRST_EXP     = 5'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXP,
    S_MID,
    S_WAIT,
    S_OUT
  } ppem_state_t;

  // Request to the power unit
  typedef struct packed {
    logic                 start;
    logic [ROOT_BITS-1:0] base;
    logic [EXP_BITS-1:0]  exp;
  } ppem_pow_req_t;

  // Status from the power unit
  typedef struct packed {
    logic busy;
    logic done;
  } ppem_pow_stat_t;

endpackage

// File: rtl/core/ppem_pow_unit.sv
// ----------------------------------------------------------------------------
// ppem_pow_unit
// Iterative saturating power: base^exp, one multiply per cycle, clamped to
// limit + 1 as soon as the running product exceeds limit.
// ----------------------------------------------------------------------------
module ppem_pow_unit
  import ppem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ppem_pow_req_t        req,
  input  logic [MAG_BITS-1:0]  limit,
  output ppem_pow_stat_t       stat,
  output logic [POW_BITS-1:0]  result
);

  logic                 busy;
  logic [EXP_BITS-1:0]  k;
  logic [EXP_BITS-1:0]  exp;
  logic [ROOT_BITS-1:0] base;
  logic [POW_BITS-1:0]  r;

  logic [PROD_BITS-1:0] prod;
  logic                 over;
  logic                 finish;

  // Shared multiplier and saturation compare
  assign prod   = r * base;
  assign over   = prod > PROD_BITS'(limit);
  assign finish = busy && (k == exp);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  // Accumulator: k counts multiplies done; saturation jumps k to the end
  always_ff @(posedge clk) begin
    if (req.start) begin
      r    <= POW_BITS'(1);
      k    <= '0;
      exp  <= req.exp;
      base <= req.base;
    end else if (busy && !finish) begin
      if (over) begin
        r <= POW_BITS'(limit) + POW_BITS'(1);
        k <= exp;
      end else begin
        r <= prod[POW_BITS-1:0];
        k <= k + EXP_BITS'(1);
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = finish;
  assign result    = r;

endmodule

// File: rtl/core/perfect_power_exponent_mask_core.sv
// ----------------------------------------------------------------------------
// perfect_power_exponent_mask_core
// Tests a signed value for being b^n (b >= 2, or one) for n in 2..max_exponent.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, value) takes one item at a time; in_ready
//   is high only while the core is idle. Output channel (out_valid/out_ready,
//   power_mask) presents one result item per input item and holds it until
//   taken; the core stays busy until then, so a stalled receiver stalls input.
//   Configuration channel (cfg_valid/cfg_ready, cfg_data) is always ready and
//   writes max_exponent; write it only while the core is idle.
// Operation:
//   Zero and negative values go straight to the output. A value of one sets
//   the bit of each enabled exponent in turn, without a search. Otherwise
//   each exponent runs a binary root search from 2 to at most 2^16, and
//   each step runs the shared saturating power unit for up to n multiplies.
//   Large exponents saturate early.
// Reset:
//   Synchronous, active high; returns to idle with max_exponent = 31.
// ----------------------------------------------------------------------------
module perfect_power_exponent_mask_core
  import ppem_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_BITS-1:0]  value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [MASK_BITS-1:0]   power_mask,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [EXP_BITS-1:0]    cfg_data
);

  ppem_state_t          state, state_next;
  logic [EXP_BITS-1:0]  max_exponent;
  logic [MAG_BITS-1:0]  v, v_next;
  logic [EXP_BITS-1:0]  top, top_next;
  logic [EXP_BITS:0]    n, n_next;
  logic [ROOT_BITS-1:0] lo, lo_next;
  logic [ROOT_BITS-1:0] hi, hi_next;
  logic [ROOT_BITS-1:0] mid, mid_next;
  logic [MASK_BITS-1:0] mask, mask_next;

  ppem_pow_req_t        pow_req;
  ppem_pow_stat_t       pow_stat;
  logic [POW_BITS-1:0]  pow_result;

  logic [ROOT_BITS:0]   bound_sum;
  logic [EXP_BITS-1:0]  bit_idx;
  logic [EXP_BITS-1:0]  cap_exp;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_exponent <= MAX_EXP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_exponent <= cfg_data;
    end
  end

  assign cap_exp   = (max_exponent > EXP_BITS'(MAX_EXP)) ? EXP_BITS'(MAX_EXP) : max_exponent;
  assign bound_sum = {1'b0, lo} + {1'b0, hi};
  // exponent counter has one spare bit so it can step past 31
  assign bit_idx   = n[EXP_BITS-1:0] - FIRST_EXP;

  // Shared power unit
  ppem_pow_unit u_pow (
    .clk    (clk),
    .rst    (rst),
    .req    (pow_req),
    .limit  (v),
    .stat   (pow_stat),
    .result (pow_result)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    v    <= v_next;
    top  <= top_next;
    n    <= n_next;
    lo   <= lo_next;
    hi   <= hi_next;
    mid  <= mid_next;
    mask <= mask_next;
  end

  // Sequencer: per exponent, binary search for an integer root
  always_comb begin
    state_next   = state;
    v_next       = v;
    top_next     = top;
    n_next       = n;
    lo_next      = lo;
    hi_next      = hi;
    mid_next     = mid;
    mask_next    = mask;
    pow_req      = '0;
    pow_req.base = mid;
    pow_req.exp  = n[EXP_BITS-1:0];
    in_ready     = 1'b0;
    out_valid    = 1'b0;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          v_next    = value[MAG_BITS-1:0];
          top_next  = cap_exp;
          n_next    = {1'b0, FIRST_EXP};
          mask_next = '0;
          // non-positive values give an empty mask
          if (value[VALUE_BITS-1] || (value == '0)) begin
            state_next = S_OUT;
          end else begin
            state_next = S_EXP;
          end
        end
      end

      S_EXP: begin
        if (n > {1'b0, top}) begin
          state_next = S_OUT;
        end else if (v == MAG_BITS'(1)) begin
          // one is a power for every exponent
          mask_next[bit_idx] = 1'b1;
          n_next             = n + (EXP_BITS+1)'(1);
        end else begin
          lo_next    = ROOT_LO;
          hi_next    = (v >= MAG_BITS'(ROOT_HI)) ? ROOT_HI : v[ROOT_BITS-1:0];
          state_next = S_MID;
        end
      end

      S_MID: begin
        if (lo > hi) begin
          n_next     = n + (EXP_BITS+1)'(1);
          state_next = S_EXP;
        end else begin
          mid_next      = bound_sum[ROOT_BITS:1];
          pow_req.start = 1'b1;
          pow_req.base  = bound_sum[ROOT_BITS:1];
          state_next    = S_WAIT;
        end
      end

      S_WAIT: begin
        if (pow_stat.done) begin
          if (pow_result == {1'b0, v}) begin
            mask_next[bit_idx] = 1'b1;
            n_next             = n + (EXP_BITS+1)'(1);
            state_next         = S_EXP;
          end else if (pow_result > {1'b0, v}) begin
            hi_next    = mid - ROOT_BITS'(1);
            state_next = S_MID;
          end else begin
            lo_next    = mid + ROOT_BITS'(1);
            state_next = S_MID;
          end
        end
      end

      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign power_mask = mask;

  // Checks
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input accepted while a result is pending");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    pow_stat.done |-> (state == S_WAIT))
    else $error("power unit finished outside of a search step");

  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    pow_req.start |-> !pow_stat.busy)
    else $error("power unit restarted while busy");

  a_mid_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (mid >= ROOT_LO) && (mid <= ROOT_HI))
    else $error("root candidate out of range");

  a_search_exp: assert property (@(posedge clk) disable iff (rst)
    (state == S_MID) |-> (n >= {1'b0, FIRST_EXP}) && (n <= {1'b0, top}))
    else $error("root search on a disabled exponent");

endmodule

// File: sim/perfect_power_exponent_mask_core_test.sv
// ----------------------------------------------------------------------------
// perfect_power_exponent_mask_core_test
// Self-checking testbench for the perfect power exponent mask core. A driver
// offers values from a queue, a predictor computes the expected exponent mask
// for each accepted item, and a monitor checks each result item in order.
// Both sides idle at random, except in the phases that set no_idle. The
// receiver also holds off once for a long stretch so the core backs up. The
// run steps through several max_exponent settings, the extremes among them.
// ----------------------------------------------------------------------------
module perfect_power_exponent_mask_core_test;
  import ppem_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] value     = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [MASK_BITS-1:0]  power_mask;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [EXP_BITS-1:0]   cfg_data  = '0;

  // Values waiting to be offered, masks waiting to come back
  logic [VALUE_BITS-1:0] value_pending_q [$];
  logic [MASK_BITS-1:0]  mask_expect_q [$];

  // Copy of max_exponent as last written
  logic [EXP_BITS-1:0]   max_exp_shadow = MAX_EXP_RESET;

  int send_gap       = 0;
  int recv_wait      = 0;
  bit no_idle        = 1'b0;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;
  int error_count    = 0;

  perfect_power_exponent_mask_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .power_mask (power_mask),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Expected mask: for each enabled exponent, binary search for an exact
  // integer root. Products stop growing once they pass the target.
  function automatic logic [MASK_BITS-1:0] expected_power_mask(
      logic [VALUE_BITS-1:0] v, logic [EXP_BITS-1:0] top_exp);
    logic [MASK_BITS-1:0] mask;
    longint unsigned target, lo, hi, mid, prod;
    int top, n, k;
    bit hit;
    mask   = '0;
    target = v;
    top    = (top_exp > MAX_EXP) ? MAX_EXP : top_exp;
    if (!v[VALUE_BITS-1] && v != '0) begin
      for (n = 2; n <= top; n++) begin
        hit = (target == 1);
        lo  = 2;
        hi  = (target < 65536) ? target : 65536;
        while (!hit && lo <= hi) begin
          mid  = lo + (hi - lo) / 2;
          prod = 1;
          for (k = 0; k < n && prod <= target; k++)
            prod = prod * mid;
          if (prod == target)
            hit = 1'b1;
          else if (prod > target)
            hi = mid - 1;
          else
            lo = mid + 1;
        end
        if (hit)
          mask[n-2] = 1'b1;
      end
    end
    return mask;
  endfunction

  // Driver: offers the next value after a random gap, predicts on accept
  always @(posedge clk) begin
    logic offering;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        mask_expect_q.push_back(expected_power_mask(value, max_exp_shadow));
        offering = 1'b0;
        send_gap = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (!offering) begin
        if (send_gap > 0)
          send_gap--;
        else if (value_pending_q.size() > 0) begin
          value <= value_pending_q.pop_front();
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // Monitor: checks each result item, then stalls at random
  always @(posedge clk) begin
    logic [MASK_BITS-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (mask_expect_q.size() == 0) begin
          $error("power_mask: no result expected, actual %h", power_mask);
          error_count++;
        end else begin
          want = mask_expect_q.pop_front();
          if (power_mask !== want) begin
            $error("power_mask: expected %h, actual %h", want, power_mask);
            error_count++;
          end
        end
        recv_wait = no_idle ? 0 : $urandom_range(0, 5);
      end
      // long hold-off so the core fills and stalls its input
      if (long_hold_req && !long_hold_done) begin
        recv_wait = 1500;
        long_hold_done = 1'b1;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed corners, then random phases under several settings
  initial begin
    logic [EXP_BITS-1:0]   exp_plan [8];
    logic [VALUE_BITS-1:0] corners [25];
    longint unsigned       pw;
    int                    ph, i, kind, n, b, k, cap;

    exp_plan = '{5'd31, 5'd2, 5'd0, 5'd1, 5'd30, 5'd0, 5'd0, 5'd31};
    exp_plan[5] = $urandom_range(0, 31);
    exp_plan[6] = $urandom_range(2, 31);
    corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'd2, 32'd3, 32'd4, 32'd8, 32'd64, 32'd729, 32'd4096,
                32'd65535, 32'd65536, 32'd131072, 32'h4000_0000,
                32'h3FFF_FFFF, 32'h4000_0001, 32'd1162261467,
                32'd2147395600, 32'd2147395599, 32'd2147395601,
                32'd1977326743, 32'h5555_5555, 32'hAAAA_AAAA};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < 8; ph++) begin
      // write max_exponent while the core is idle
      @(posedge clk);
      cfg_data  <= exp_plan[ph];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      max_exp_shadow = exp_plan[ph];
      cfg_valid <= 1'b0;

      no_idle = (ph % 3 == 2);
      if (ph == 0) begin
        foreach (corners[i])
          value_pending_q.push_back(corners[i]);
      end else begin
        for (i = 0; i < 70; i++) begin
          kind = $urandom_range(0, 99);
          if (kind < 55) begin
            // exact power b^n, sometimes nudged by one
            do begin
              n   = $urandom_range(2, 30);
              cap = (n == 2) ? 46340 : (1 << (31 / n));
              b   = $urandom_range(2, cap);
              pw  = 1;
              for (k = 0; k < n; k++)
                pw = pw * b;
            end while (pw > 64'h7FFF_FFFF);
            if (kind >= 40)
              pw = $urandom_range(0, 1) ? pw + 1 : pw - 1;
            value_pending_q.push_back(pw[VALUE_BITS-1:0]);
          end else if (kind < 70) begin
            value_pending_q.push_back($urandom_range(0, 300));
          end else if (kind < 80) begin
            value_pending_q.push_back($urandom | 32'h8000_0000);
          end else begin
            value_pending_q.push_back($urandom);
          end
        end
        if (ph == 4)
          long_hold_req = 1'b1;
      end

      // drain before the next register write; sample away from the active edge
      while (value_pending_q.size() != 0 || in_valid || mask_expect_q.size() != 0)
        @(negedge clk);
    end

    // catch any stray result items
    repeat (50) @(posedge clk);
    if (error_count == 0)
      $display("perfect_power_exponent_mask_core regression: pass");
    else
      $display("perfect_power_exponent_mask_core regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #200000000;
    $display("perfect_power_exponent_mask_core regression: fail");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ppem_pkg.sv
rtl/core/ppem_pow_unit.sv
rtl/core/perfect_power_exponent_mask_core.sv
sim/perfect_power_exponent_mask_core_test.sv
